>>> hw/rtl/ert_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ert_pkg;

	// Table geometry.
	localparam int unsigned SLOTS = 128;
	localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CNT_W = IDX_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

	// Field widths.
	localparam int unsigned SEQ_W = 16;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned RTT_W = 23;
	localparam int unsigned LEN_W = 16;

	// Protocol constants.
	localparam logic [7:0] ECHO_REPLY = 8'd0;
	localparam logic [LEN_W-1:0] MIN_MSG = LEN_W'(8);

	// Microseconds to milliseconds. The quotient by 1000 is the top bits of the
	// product with ceil(2^38 / 1000), which is exact for every 32-bit value.
	localparam int unsigned DIV_BY = 1000;
	localparam int unsigned RECIP_W = 29;
	localparam int unsigned RECIP_SH = 38;
	localparam logic [RECIP_W-1:0] RECIP = 29'd274877907;
	localparam int unsigned PROD_W = TIME_W + RECIP_W;

	typedef enum logic [2:0] {
		STAT_TRACKED   = 3'd0,
		STAT_UNTRACKED = 3'd1,
		STAT_MATCHED   = 3'd2,
		STAT_SHORT     = 3'd3,
		STAT_FOREIGN   = 3'd4,
		STAT_UNKNOWN   = 3'd5
	} stat_e;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_FREE,
		S_MATCH,
		S_DIV,
		S_EMIT
	} state_e;

	typedef struct packed {
		logic              mode;
		logic [TIME_W-1:0] time_us;
		logic [SEQ_W-1:0]  reply_seq;
		logic [7:0]        reply_type;
		logic [15:0]       reply_ident;
		logic [3:0]        header_words;
		logic [LEN_W-1:0]  packet_length;
	} in_t;

	typedef struct packed {
		stat_e             status;
		logic [SEQ_W-1:0]  seq_out;
		logic [RTT_W-1:0]  rtt_ms;
		logic [LEN_W-1:0]  message_length;
		logic [SEQ_W-1:0]  sent_count;
		logic [SEQ_W-1:0]  received_count;
	} out_t;

	typedef struct packed {
		logic  load;
		logic  free_step;
		logic  match_step;
		logic  div_step;
		logic  seq_bump;
		logic  set_status;
		stat_e code;
		logic  emit;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic free_hit;
		logic free_last;
		logic short_pkt;
		logic foreign;
		logic match_hit;
		logic match_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/ert_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ert_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/ert_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ert_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire ert_pkg::sts_t sts,
	output ert_pkg::cmd_t      cmd
);

	import ert_pkg::*;

	state_e state_q;
	state_e state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!sts.mode) begin
					state_d = S_FREE;
				end else if (sts.short_pkt || sts.foreign) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_MATCH;
				end
			end
			S_FREE: begin
				if (sts.free_hit || sts.free_last) begin
					state_d = S_EMIT;
				end
			end
			S_MATCH: begin
				if (sts.match_hit) begin
					state_d = S_DIV;
				end else if (sts.match_last) begin
					state_d = S_EMIT;
				end
			end
			S_DIV: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.code = STAT_TRACKED;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_CHECK: begin
				if (sts.mode) begin
					// Length is checked before type and identifier.
					if (sts.short_pkt) begin
						cmd.set_status = 1'b1;
						cmd.code = STAT_SHORT;
					end else if (sts.foreign) begin
						cmd.set_status = 1'b1;
						cmd.code = STAT_FOREIGN;
					end
				end
			end
			S_FREE: begin
				cmd.free_step = 1'b1;
				if (sts.free_hit) begin
					cmd.set_status = 1'b1;
					cmd.code = STAT_TRACKED;
					cmd.seq_bump = 1'b1;
				end else if (sts.free_last) begin
					cmd.set_status = 1'b1;
					cmd.code = STAT_UNTRACKED;
					cmd.seq_bump = 1'b1;
				end
			end
			S_MATCH: begin
				cmd.match_step = 1'b1;
				if (sts.match_hit) begin
					cmd.set_status = 1'b1;
					cmd.code = STAT_MATCHED;
				end else if (sts.match_last) begin
					cmd.set_status = 1'b1;
					cmd.code = STAT_UNKNOWN;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/ert_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ert_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [15:0]   cfg_wdata,
	input  wire ert_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output ert_pkg::out_t      out_data,
	input  wire ert_pkg::cmd_t cmd,
	output ert_pkg::sts_t      sts
);

	import ert_pkg::*;

	// Control state.
	logic [15:0]      own_id_q;
	logic [SEQ_W-1:0] next_seq_q;
	logic [SEQ_W-1:0] reply_total_q;
	logic [SLOTS-1:0] busy_q;
	logic             out_valid_q;

	// Working registers of the current item.
	in_t                  item_q;
	stat_e                status_q;
	logic [SEQ_W-1:0]     res_seq_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic                 rd_vld_s1;
	logic [TIME_W-1:0]    div_q;
	logic [RTT_W-1:0]     quot_q;
	out_t                 out_q;

	logic [IDX_W-1:0]  idx;
	logic              cnt_in_range;
	logic [SEQ_W-1:0]  seq_rdata;
	logic [TIME_W-1:0] time_rdata;
	logic              ram_we;
	logic              match_hit;
	logic [LEN_W:0]    msg_s;
	logic              msg_neg;
	logic [LEN_W-1:0]  mlen;
	logic [PROD_W-1:0] prod;
	logic              out_free;

	assign idx = cnt_q[IDX_W-1:0];
	assign cnt_in_range = cnt_q < SLOTS_C;
	assign ram_we = cmd.free_step && !busy_q[idx];

	ert_ram #(
		.WIDTH(SEQ_W),
		.DEPTH(SLOTS)
	) u_seq_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx),
		.wdata(next_seq_q),
		.raddr(idx),
		.rdata(seq_rdata)
	);

	ert_ram #(
		.WIDTH(TIME_W),
		.DEPTH(SLOTS)
	) u_time_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx),
		.wdata(item_q.time_us),
		.raddr(idx),
		.rdata(time_rdata)
	);

	// Busy bits cannot change during a scan, so the bit for the returned entry is current.
	assign match_hit = rd_vld_s1 && busy_q[rd_idx_s1] && (seq_rdata == item_q.reply_seq);

	// Length after the IP header, with a sign bit.
	assign msg_s = {1'b0, item_q.packet_length}
		- {{(LEN_W - 5){1'b0}}, item_q.header_words, 2'b00};
	assign msg_neg = msg_s[LEN_W];
	assign mlen = msg_neg ? '0 : msg_s[LEN_W-1:0];

	// Division by 1000 as a multiplication by the scaled reciprocal. The elapsed
	// time is registered first, so the multiplier lies alone between div_q and quot_q.
	assign prod = {{RECIP_W{1'b0}}, div_q} * {{TIME_W{1'b0}}, RECIP};

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		sts.mode = item_q.mode;
		sts.free_hit = !busy_q[idx];
		sts.free_last = idx == LAST_IDX;
		sts.short_pkt = msg_neg || (msg_s[LEN_W-1:0] < MIN_MSG);
		sts.foreign = (item_q.reply_type != ECHO_REPLY) || (item_q.reply_ident != own_id_q);
		sts.match_hit = match_hit;
		sts.match_last = rd_vld_s1 && (rd_idx_s1 == LAST_IDX);
		sts.out_free = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
			next_seq_q <= '0;
			reply_total_q <= '0;
			busy_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				own_id_q <= cfg_wdata;
			end
			if (cmd.seq_bump) begin
				next_seq_q <= next_seq_q + 1'b1;
			end
			if (ram_we) begin
				busy_q[idx] <= 1'b1;
			end
			if (cmd.match_step && match_hit) begin
				busy_q[rd_idx_s1] <= 1'b0;
				reply_total_q <= reply_total_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
			res_seq_q <= in_data.mode ? in_data.reply_seq : next_seq_q;
			cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
		end
		if (cmd.set_status) begin
			status_q <= cmd.code;
		end
		if (cmd.free_step && busy_q[idx]) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.match_step) begin
			rd_idx_s1 <= idx;
			rd_vld_s1 <= cnt_in_range;
			if (cnt_in_range) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (match_hit) begin
				div_q <= item_q.time_us - time_rdata;
			end
		end
		if (cmd.div_step) begin
			quot_q <= prod[PROD_W-1:RECIP_SH];
		end
		if (cmd.emit) begin
			out_q.status <= status_q;
			out_q.seq_out <= res_seq_q;
			out_q.rtt_ms <= (status_q == STAT_MATCHED) ? quot_q : '0;
			out_q.message_length <= item_q.mode ? mlen : '0;
			out_q.sent_count <= next_seq_q;
			out_q.received_count <= reply_total_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/echo_request_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Echo request tracker. A send beat takes the next 16-bit sequence number and
// stores it with its microsecond time stamp in the lowest free slot of a
// 128-entry table, if one is free; a reply beat is checked for length, type
// and identifier, then matched by sequence against occupied slots, freeing
// the slot and giving the round trip time in milliseconds. One item is worked
// at a time. A send runs a free-slot scan that tests one busy bit per cycle.
// A reply that passes its checks runs a sequence scan that reads one table
// entry per cycle from single-port-read memories; when a slot matches, the
// S_DIV state then turns the elapsed microseconds into milliseconds by a
// reciprocal multiplication. A finished result waits in an output register,
// and the next item is accepted while it waits.
module echo_request_tracker_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [15:0]  cfg_wdata,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire ert_pkg::in_t in_data,
	output logic              out_valid,
	input  wire logic         out_stall,
	output ert_pkg::out_t     out_data
);

	import ert_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ert_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	ert_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

`default_nettype wire
